FILE: design/sai_pkg.sv
// Shared types and constants for the sorted table insert block.
`timescale 1ns / 1ps

package sai_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_BAD_SLOT  = 2'd2;

   localparam logic CMD_SORTED = 1'b0;
   localparam logic CMD_AT_SLOT = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [31:0] item_value;
      logic [4:0]         target_slot;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         slot_number;
      logic signed [31:0] element_value;
      logic [4:0]         placed_at;
      logic [4:0]         fill_count;
      logic               last_of_run;
   } rsp_word_type;

endpackage

FILE: design/sorted_array_insert.sv
// Sorted table insert: memory-held ordered table with search, shift and full readout.
`timescale 1ns / 1ps

// One request word inserts a signed value into a table of up to DEPTH entries, either in
// sorted order (after any equal values) or at a given slot, and then returns the whole table
// as one response word per entry in slot order, the final word flagged by last_of_run. A full
// table, or a slot beyond the fill count, returns one error word and changes nothing. The
// table lives in a synchronous memory with one read and one write port, so each step handles
// one entry at a time: a sorted insert searches from slot 0 for the first larger value (an
// empty table skips this), shifts the entries from that slot upward, places the item and
// then reads the table out; an insert at a slot skips the search; an error word needs
// neither. Readout stalls with rsp_ready. Reset clears the fill count; the memory needs no
// clearing.
module sorted_array_insert #(
   parameter int DEPTH = sai_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sai_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sai_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_SEARCH      = 3'd1;
   localparam logic [2:0] ST_SHIFT_START = 3'd2;
   localparam logic [2:0] ST_SHIFT       = 3'd3;
   localparam logic [2:0] ST_PLACE       = 3'd4;
   localparam logic [2:0] ST_READ        = 3'd5;
   localparam logic [2:0] ST_LOAD        = 3'd6;

   logic signed [31:0]    table_mem_ff [DEPTH];
   logic signed [31:0]    rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic signed [31:0]    wr_data;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic signed [31:0]    item_ff, item_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sai_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  out_free;
   logic                  accept;
   logic                  is_full;
   logic                  bad_slot;
   logic [CNT_W-1:0]      idx_next_cnt;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_valid && req_ready;
   assign is_full      = (count_ff == CNT_W'(DEPTH));
   assign bad_slot     = CMP_W'(req_word.target_slot) > CMP_W'(count_ff);
   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      item_in      = item_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (accept) begin
               item_in = req_word.item_value;
               if (is_full || (req_word.command == sai_pkg::CMD_AT_SLOT && bad_slot)) begin
                  rsp_valid_in              = 1'b1;
                  rsp_word_in.status        = is_full ? sai_pkg::STATUS_FULL
                                                      : sai_pkg::STATUS_BAD_SLOT;
                  rsp_word_in.slot_number   = '0;
                  rsp_word_in.element_value = '0;
                  rsp_word_in.placed_at     = '0;
                  rsp_word_in.fill_count    = 5'(count_ff);
                  rsp_word_in.last_of_run   = 1'b1;
               end else if (req_word.command == sai_pkg::CMD_AT_SLOT) begin
                  pos_in   = IDX_W'(req_word.target_slot);
                  state_in = ST_SHIFT_START;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_SHIFT_START;
               end else begin
                  idx_in   = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (item_ff < rd_data_ff) begin
               pos_in   = idx_ff;
               state_in = ST_SHIFT_START;
            end else if (idx_next_cnt == count_ff) begin
               pos_in   = IDX_W'(count_ff);
               state_in = ST_SHIFT_START;
            end else begin
               rd_addr = idx_ff + IDX_W'(1);
               idx_in  = idx_ff + IDX_W'(1);
            end
         end
         ST_SHIFT_START: begin
            rd_addr = IDX_W'(count_ff - CNT_W'(1));
            idx_in  = IDX_W'(count_ff);
            if (CNT_W'(pos_ff) == count_ff) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            if (idx_ff - IDX_W'(1) == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               rd_addr = idx_ff - IDX_W'(2);
               idx_in  = idx_ff - IDX_W'(1);
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = item_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_addr  = '0;
            idx_in   = '0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.status        = sai_pkg::STATUS_OK;
               rsp_word_in.slot_number   = 4'(idx_ff);
               rsp_word_in.element_value = rd_data_ff;
               rsp_word_in.placed_at     = 5'(pos_ff);
               rsp_word_in.fill_count    = 5'(count_ff);
               rsp_word_in.last_of_run   = (idx_next_cnt == count_ff);
               if (idx_next_cnt == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr = idx_ff + IDX_W'(1);
                  idx_in  = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_count_only_on_place: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_PLACE |=> count_ff == $past(count_ff))
      else $error("fill count changed outside placement");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status != sai_pkg::STATUS_OK |-> rsp_word_ff.last_of_run)
      else $error("error word not marked last");

   a_good_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept && !is_full && !(req_word.command == sai_pkg::CMD_AT_SLOT && bad_slot)
      |=> state_ff != ST_IDLE)
      else $error("accepted insert did not start");

   a_place_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> CNT_W'(pos_ff) <= count_ff && count_ff < CNT_W'(DEPTH))
      else $error("placement slot out of range");

endmodule
